FILE: src/rle_row_copy_decoder_core_defines.svh
// Assertion macros used by the decoder top level.
`ifndef RLE_ROW_COPY_DECODER_CORE_DEFINES_SVH
`define RLE_ROW_COPY_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define RRCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define RRCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rrcd_pkg.sv
// Types and constants of the run-length row-copy decoder.
`timescale 1ns / 1ps

package rrcd_pkg;

    typedef enum logic [1:0] {
        K_LIT  = 2'd0,
        K_RUN  = 2'd1,
        K_COPY = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [15:0] count;
        logic        done_res;
    } t_result;

    typedef struct packed {
        logic stopped;
    } t_front_stat;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_LONG_CODES = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd1;
    localparam logic [1:0] REG_MAX_OUTPUT = 2'd2;

    localparam logic [15:0] ROW_WIDTH_RESET  = 16'd320;
    localparam logic [31:0] MAX_OUTPUT_RESET = 32'd64000;

    // Code bytes
    localparam logic [7:0] CODE_LIT_ALL   = 8'h00;
    localparam logic [7:0] CODE_LIT_SHORT = 8'h7e;
    localparam logic [7:0] CODE_LIT_LONG  = 8'h7f;
    localparam logic [7:0] CODE_RUN_FIRST = 8'h81;
    localparam logic [7:0] CODE_RUN_SHORT = 8'hfc;
    localparam logic [7:0] CODE_COPY_LONG = 8'hfd;
    localparam logic [7:0] CODE_COPY_BYTE = 8'hfe;
    localparam logic [7:0] CODE_RUN_LONG  = 8'hff;

    localparam int RRCD_QUEUE_DEPTH = 4;

endpackage

FILE: src/rrcd_if.sv
// Stream interfaces for compressed input bytes and decoded result words.
`timescale 1ns / 1ps

interface rrcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface rrcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] count;
    logic        done_res;

    modport source (output valid, output kind, output value, output count,
                    output done_res, input ready);
    modport sink   (input valid, input kind, input value, input count,
                    input done_res, output ready);
endinterface

FILE: src/rrcd_front.sv
// Code-byte parser: classifies each byte, keeps the output total, builds result words.
`timescale 1ns / 1ps

module rrcd_front import rrcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_long_codes,
    input  logic [15:0] i_row_width,
    input  logic [31:0] i_max_output,
    output logic        o_push,
    output t_result     o_res,
    output t_front_stat o_stat
);

    typedef enum logic [7:0] {
        PH_CODE   = 8'b0000_0001,
        PH_LIT    = 8'b0000_0010,
        PH_LITALL = 8'b0000_0100,
        PH_LENLO  = 8'b0000_1000,
        PH_LENHI  = 8'b0001_0000,
        PH_RUNVAL = 8'b0010_0000,
        PH_COPY8  = 8'b0100_0000,
        PH_STOP   = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    t_kind       r_pend, n_pend;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_left, n_left;
    logic [31:0] r_total, n_total;

    logic [7:0]  max_lit;
    logic [7:0]  max_run;
    logic        copy_req;
    logic [15:0] copy_n;
    logic [15:0] len16;
    logic [32:0] sum;
    logic        done;

    assign max_lit = i_long_codes ? CODE_LIT_SHORT : CODE_LIT_LONG;
    assign max_run = i_long_codes ? CODE_RUN_SHORT : CODE_RUN_LONG;
    assign len16   = {i_byte, r_low};

    always_comb begin
        n_phase        = r_phase;
        n_pend         = r_pend;
        n_low          = r_low;
        n_left         = r_left;
        n_total        = r_total;
        o_push         = 1'b0;
        o_res.kind     = K_LIT;
        o_res.value    = 8'd0;
        o_res.count    = 16'd0;
        copy_req       = 1'b0;
        copy_n         = 16'd0;
        done           = 1'b0;
        if (i_accept) begin
            case (r_phase)
                PH_CODE: begin
                    if (r_total >= i_max_output) begin
                        n_phase = PH_STOP;
                    end else if (i_byte == CODE_LIT_ALL) begin
                        n_phase = PH_LITALL;
                    end else if (i_byte <= max_lit) begin
                        n_left  = {8'd0, i_byte};
                        n_phase = PH_LIT;
                    end else if (i_byte == CODE_LIT_LONG) begin
                        n_pend  = K_LIT;
                        n_phase = PH_LENLO;
                    end else if (i_byte >= CODE_RUN_FIRST && i_byte <= max_run) begin
                        n_left  = {9'd0, i_byte[6:0]};
                        n_phase = PH_RUNVAL;
                    end else if (i_byte == CODE_COPY_LONG) begin
                        n_pend  = K_COPY;
                        n_phase = PH_LENLO;
                    end else if (i_byte == CODE_COPY_BYTE) begin
                        n_phase = PH_COPY8;
                    end else if (i_byte == CODE_RUN_LONG) begin
                        n_pend  = K_RUN;
                        n_phase = PH_LENLO;
                    end else begin
                        o_push     = 1'b1;
                        o_res.kind = K_ERR;
                    end
                end
                PH_LIT: begin
                    if (r_left <= 16'd1) begin
                        n_left  = 16'd0;
                        n_phase = PH_CODE;
                    end else begin
                        n_left = r_left - 16'd1;
                    end
                    o_push      = 1'b1;
                    o_res.value = i_byte;
                    o_res.count = 16'd1;
                end
                PH_LITALL: begin
                    o_push      = 1'b1;
                    o_res.value = i_byte;
                    o_res.count = 16'd1;
                end
                PH_LENLO: begin
                    n_low   = i_byte;
                    n_phase = PH_LENHI;
                end
                PH_LENHI: begin
                    if (r_pend == K_LIT) begin
                        n_left  = len16;
                        n_phase = (len16 != 16'd0) ? PH_LIT : PH_CODE;
                    end else if (r_pend == K_RUN) begin
                        n_left  = len16;
                        n_phase = PH_RUNVAL;
                    end else begin
                        copy_req = 1'b1;
                        copy_n   = len16;
                    end
                end
                PH_COPY8: begin
                    copy_req = 1'b1;
                    copy_n   = {8'd0, i_byte};
                end
                PH_RUNVAL: begin
                    n_phase     = PH_CODE;
                    o_push      = 1'b1;
                    o_res.kind  = K_RUN;
                    o_res.value = i_byte;
                    o_res.count = r_left;
                end
                PH_STOP: begin
                    n_phase = PH_STOP;
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end

        if (copy_req) begin
            o_push = 1'b1;
            if (copy_n > i_row_width) begin
                o_res.kind = K_ERR;
            end else begin
                n_phase     = PH_CODE;
                o_res.kind  = K_COPY;
                o_res.count = copy_n;
            end
        end

        sum = {1'b0, r_total} + {17'd0, o_res.count};

        // Errors stop at once; other results add in, saturating, then meet the limit
        if (o_push) begin
            if (o_res.kind == K_ERR) begin
                done = 1'b1;
            end else begin
                n_total = sum[32] ? 32'hffff_ffff : sum[31:0];
                done    = (n_total >= i_max_output);
            end
        end
        if (done) begin
            n_phase = PH_STOP;
        end
        o_res.done_res = done;
    end

    assign o_stat.stopped = (r_phase == PH_STOP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_pend  <= K_LIT;
            r_low   <= 8'd0;
            r_left  <= 16'd0;
            r_total <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_low   <= n_low;
            r_left  <= n_left;
            r_total <= n_total;
        end
    end

endmodule

FILE: src/rrcd_queue.sv
// Result queue between the parser and the output channel.
`timescale 1ns / 1ps

module rrcd_queue import rrcd_pkg::*; #(
    parameter int DEPTH = RRCD_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_can_push,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          pop;

    assign o_valid    = (r_cnt != CW'(0));
    assign o_res      = r_mem[r_rd];
    assign pop        = o_valid && i_pop_ready;
    // A pop in the same cycle frees a slot for the incoming word
    assign o_can_push = (r_cnt != CW'(DEPTH)) || pop;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? PW'(0) : r_wr + PW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? PW'(0) : r_rd + PW'(1);
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: src/rle_row_copy_decoder_core.sv
// Top level of the run-length decoder with copy from the previous row.
`timescale 1ns / 1ps
`include "rle_row_copy_decoder_core_defines.svh"

// The decoder takes one compressed byte per word on i_in and parses it as
// code bytes, literal bytes, fill bytes and 8- or 16-bit lengths (low byte
// first); it returns one word on o_out per literal byte, per run, per copy
// from the previous row, or for an error (code 0x80, or a copy longer than
// row_width). Input is taken at one byte per clock while i_in.ready is
// high: the parser settles each byte in the cycle it arrives, including the
// saturating add of the output total and its compare against max_output,
// and pushes any result word into a QUEUE_DEPTH-entry queue. i_in.ready
// drops only while the queue is full and o_out is stalled. Once a result
// carries done_res, or a code byte meets a total at or above max_output,
// the block stops: later bytes are still taken and dropped, and only reset
// restarts it. APB registers (byte address 0 long_codes, 4 row_width,
// 8 max_output) must be written only while idle; the block does not check.
module rle_row_copy_decoder_core import rrcd_pkg::*; #(
    parameter int QUEUE_DEPTH = RRCD_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rrcd_in_if.sink       i_in,
    rrcd_out_if.source    o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic        r_long_codes;
    logic [15:0] r_row_width;
    logic [31:0] r_max_output;

    logic        cfg_wr;
    logic        in_accept;
    logic        front_push;
    t_result     front_res;
    t_front_stat front_stat;
    logic        q_can_push;
    logic        q_valid;
    t_result     q_res;

    // Configuration port: zero wait states, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_codes <= 1'b0;
            r_row_width  <= ROW_WIDTH_RESET;
            r_max_output <= MAX_OUTPUT_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LONG_CODES: r_long_codes <= pwdata[0];
                REG_ROW_WIDTH:  r_row_width  <= pwdata[15:0];
                REG_MAX_OUTPUT: r_max_output <= pwdata;
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LONG_CODES: prdata = {31'd0, r_long_codes};
            REG_ROW_WIDTH:  prdata = {16'd0, r_row_width};
            REG_MAX_OUTPUT: prdata = r_max_output;
            default:        prdata = 32'd0;
        endcase
    end

    // Front: take a byte whenever the queue has room for what it may cause
    assign i_in.ready = q_can_push;
    assign in_accept  = i_in.valid && q_can_push;

    rrcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_byte       (i_in.in_byte),
        .i_long_codes (r_long_codes),
        .i_row_width  (r_row_width),
        .i_max_output (r_max_output),
        .o_push       (front_push),
        .o_res        (front_res),
        .o_stat       (front_stat)
    );

    // Back: hold result words until the downstream writer takes them
    rrcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_res       (front_res),
        .o_can_push  (q_can_push),
        .o_valid     (q_valid),
        .o_res       (q_res),
        .i_pop_ready (o_out.ready)
    );

    assign o_out.valid    = q_valid;
    assign o_out.kind     = q_res.kind;
    assign o_out.value    = q_res.value;
    assign o_out.count    = q_res.count;
    assign o_out.done_res = q_res.done_res;

    `RRCD_ASSERT_NOW(a_err_is_done, q_valid && (q_res.kind == K_ERR), q_res.done_res, "error word without done_res")
    `RRCD_ASSERT_NOW(a_lit_count_one, q_valid && (q_res.kind == K_LIT), q_res.count == 16'd1, "literal word with count other than one")
    `RRCD_ASSERT_NEXT(a_done_stops, front_push && front_res.done_res, front_stat.stopped, "parser kept running after a done word")
    `RRCD_ASSERT_NEXT(a_stop_sticky, front_stat.stopped, front_stat.stopped && !front_push, "parser left the stopped state")

endmodule
